[design/iqs_pkg.sv]
// Shared constants, types and state encodings for the quicksort engine.
package iqs_pkg;
    localparam int MAX_ITEMS_DEF   = 64;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int VAL_W           = 32;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_POP, S_POPW, S_PIV, S_SCAN, S_SCANW,
        S_SWAP, S_FIN, S_FINW, S_FINSWAP, S_OUTR, S_OUTW, S_OUT
    } t_state;
endpackage

[design/iqs_if.sv]
// Valid/ready channel interface carrying one payload.
interface iqs_if #(parameter int W = 33);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/iqs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module iqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

[design/iqs_front.sv]
// Input front end: two-entry request queue between the port and the sorter.
module iqs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iqs_if.sink           s_in,
    input  logic          i_pop,
    output logic          o_avail,
    output iqs_pkg::t_req o_req
);
    iqs_pkg::t_req r_q [2];
    logic [1:0]    r_cnt;
    logic          push;

    assign push    = s_in.valid && s_in.ready;
    assign s_in.ready = (r_cnt != 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_req   = r_q[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop && o_avail};
        end
        if (i_pop && o_avail) begin
            r_q[0] <= r_q[1];
            if (push) begin
                if (r_cnt == 2'd1) r_q[0] <= s_in.data;
                else               r_q[1] <= s_in.data;
            end
        end else if (push) begin
            if (r_cnt == 2'd0) r_q[0] <= s_in.data;
            else               r_q[1] <= s_in.data;
        end
    end
endmodule

[design/iqs_back.sv]
// Back end: element store, range stack, Lomuto partition sequencer and output.
module iqs_back #(
    parameter int MAX_ITEMS   = iqs_pkg::MAX_ITEMS_DEF,
    parameter int STACK_DEPTH = iqs_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_avail,
    input  iqs_pkg::t_req i_req,
    output logic          o_pop,
    iqs_if.source         m_out
);
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = IW + 1;
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = SW + 1;
    localparam int VW = iqs_pkg::VAL_W;

    iqs_pkg::t_state r_st, n_st;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_sp, n_sp;
    logic          r_drop, n_drop;
    logic [IW-1:0] r_lo, n_lo, r_hi, n_hi, r_j, n_j, r_slot, n_slot;
    logic [VW-1:0] r_piv, n_piv, r_a, n_a;
    logic [CW-1:0] r_k, n_k;
    logic [1:0]    r_push, n_push;
    logic          r_ov, n_ov;
    logic [VW-1:0] r_oval, n_oval;
    logic          r_oend, n_oend, r_ovf, n_ovf;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [VW-1:0] wdata, rdata;
    logic          swe;
    logic [SW-1:0] swaddr, sraddr;
    logic [2*IW-1:0] swdata, srdata;

    iqs_ram #(.WIDTH(VW), .DEPTH(MAX_ITEMS)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata));
    iqs_ram #(.WIDTH(2*IW), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(swe), .i_waddr(swaddr), .i_wdata(swdata),
        .i_raddr(sraddr), .o_rdata(srdata));

    assign m_out.valid = r_ov;
    assign m_out.data  = {r_oval, r_oend, r_ovf};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= iqs_pkg::S_IDLE;
            r_cnt  <= '0;
            r_sp   <= '0;
            r_drop <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_cnt  <= n_cnt;
            r_sp   <= n_sp;
            r_drop <= n_drop;
            r_ov   <= n_ov;
        end
        r_lo <= n_lo; r_hi <= n_hi; r_j <= n_j; r_slot <= n_slot;
        r_piv <= n_piv; r_a <= n_a; r_k <= n_k; r_push <= n_push;
        r_oval <= n_oval; r_oend <= n_oend; r_ovf <= n_ovf;
    end

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_sp = r_sp; n_drop = r_drop;
        n_lo = r_lo; n_hi = r_hi; n_j = r_j; n_slot = r_slot;
        n_piv = r_piv; n_a = r_a; n_k = r_k; n_push = r_push;
        n_ov = r_ov; n_oval = r_oval; n_oend = r_oend; n_ovf = r_ovf;
        o_pop = 1'b0;
        we = 1'b0; waddr = '0; wdata = rdata; raddr = r_j;
        swe = 1'b0; swaddr = r_sp[SW-1:0]; swdata = {r_lo, r_hi};
        sraddr = r_sp[SW-1:0] - 1'b1;
        if (m_out.ready) n_ov = 1'b0;
        case (r_st)
            iqs_pkg::S_IDLE: begin
                if (i_avail) begin
                    o_pop = 1'b1;
                    if (r_cnt < CW'(MAX_ITEMS)) begin
                        we = 1'b1; waddr = r_cnt[IW-1:0]; wdata = i_req.value;
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_req.last) n_st = iqs_pkg::S_START;
                end
            end
            iqs_pkg::S_START: begin
                n_sp = '0;
                n_k  = '0;
                if (r_cnt < CW'(2)) begin
                    n_st = iqs_pkg::S_OUTR;
                end else begin
                    swe = 1'b1; swaddr = '0;
                    swdata = {IW'(0), IW'(r_cnt - 1'b1)};
                    n_sp = PW'(1);
                    n_st = iqs_pkg::S_POP;
                end
            end
            iqs_pkg::S_POP: begin
                if (r_sp == '0) begin
                    n_k = '0; n_st = iqs_pkg::S_OUTR;
                end else begin
                    n_sp = r_sp - 1'b1;
                    n_st = iqs_pkg::S_POPW;
                end
            end
            iqs_pkg::S_POPW: begin
                n_lo = srdata[2*IW-1:IW];
                n_hi = srdata[IW-1:0];
                raddr = srdata[IW-1:0];
                if (srdata[2*IW-1:IW] >= srdata[IW-1:0]) n_st = iqs_pkg::S_POP;
                else n_st = iqs_pkg::S_PIV;
            end
            iqs_pkg::S_PIV: begin
                n_piv = rdata; n_j = r_lo; n_slot = r_lo;
                raddr = r_lo;
                n_st = iqs_pkg::S_SCAN;
            end
            iqs_pkg::S_SCAN: begin
                if (r_j == r_hi) begin
                    raddr = r_slot; n_st = iqs_pkg::S_FIN;
                end else if ($signed(rdata) <= $signed(r_piv)) begin
                    n_a = rdata; raddr = r_slot; n_st = iqs_pkg::S_SWAP;
                end else begin
                    n_j = r_j + 1'b1; raddr = r_j + 1'b1;
                end
            end
            iqs_pkg::S_SWAP: begin
                we = 1'b1; waddr = r_j; wdata = rdata;
                n_st = iqs_pkg::S_SCANW;
            end
            iqs_pkg::S_SCANW: begin
                we = 1'b1; waddr = r_slot; wdata = r_a;
                n_slot = r_slot + 1'b1;
                n_j = r_j + 1'b1; raddr = r_j + 1'b1;
                n_st = iqs_pkg::S_SCAN;
            end
            iqs_pkg::S_FIN: begin
                n_a = rdata;
                we = 1'b1; waddr = r_slot; wdata = r_piv;
                n_st = iqs_pkg::S_FINW;
            end
            iqs_pkg::S_FINW: begin
                we = 1'b1; waddr = r_hi; wdata = r_a;
                n_push = {(r_slot > r_lo + 1'b1) && (r_slot != r_lo),
                          ({1'b0, r_slot} + 1'b1) < {1'b0, r_hi}};
                n_st = iqs_pkg::S_FINSWAP;
            end
            iqs_pkg::S_FINSWAP: begin
                if (r_push[1]) begin
                    swe = (r_sp < PW'(STACK_DEPTH));
                    swdata = {r_lo, r_slot - 1'b1};
                    if (swe) n_sp = r_sp + 1'b1;
                    n_push[1] = 1'b0;
                end else if (r_push[0]) begin
                    swe = (r_sp < PW'(STACK_DEPTH));
                    swdata = {r_slot + 1'b1, r_hi};
                    if (swe) n_sp = r_sp + 1'b1;
                    n_push[0] = 1'b0;
                end else begin
                    n_st = iqs_pkg::S_POP;
                end
            end
            iqs_pkg::S_OUTR: begin
                raddr = r_k[IW-1:0];
                n_st = iqs_pkg::S_OUTW;
            end
            iqs_pkg::S_OUTW: begin
                raddr = r_k[IW-1:0];
                n_st = iqs_pkg::S_OUT;
            end
            iqs_pkg::S_OUT: begin
                raddr = r_k[IW-1:0];
                if (!r_ov || m_out.ready) begin
                    n_ov = 1'b1; n_oval = rdata;
                    n_oend = (r_k + 1'b1 == r_cnt); n_ovf = r_drop;
                    n_k = r_k + 1'b1;
                    if (r_k + 1'b1 == r_cnt) begin
                        n_cnt = '0; n_drop = 1'b0; n_sp = '0;
                        n_st = iqs_pkg::S_IDLE;
                    end else begin
                        n_st = iqs_pkg::S_OUTR;
                    end
                end
            end
            default: n_st = iqs_pkg::S_IDLE;
        endcase
        if (r_st == iqs_pkg::S_START && r_cnt == '0) begin
            n_cnt = '0; n_drop = 1'b0; n_st = iqs_pkg::S_IDLE;
        end
    end
endmodule

[design/iterative_quicksort_engine_top.sv]
// Top level of the quicksort engine: request queue, sorter and assertions.
// Values are collected one request per cycle, while the sorter is idle,
// into a store of MAX_ITEMS entries; the request flagged final starts an
// in-place Lomuto quicksort driven by a range stack in RAM. A partition
// reads the entries of its range, and those it swaps, through the single
// read port of the element store. Results then leave in order, each read
// from the store through S_OUTR, S_OUTW and S_OUT, and a new result is not
// presented until the last one has been taken. Only one set is sorted at a
// time; the input queue takes up to two requests while a sort is running.
module iterative_quicksort_engine_top #(
    parameter int MAX_ITEMS   = iqs_pkg::MAX_ITEMS_DEF,
    parameter int STACK_DEPTH = iqs_pkg::STACK_DEPTH_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    iqs_if.sink   s_in,
    iqs_if.source m_out
);
    logic          pop, avail;
    iqs_pkg::t_req req;

    iqs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in),
        .i_pop(pop), .o_avail(avail), .o_req(req));

    iqs_back #(.MAX_ITEMS(MAX_ITEMS), .STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(avail), .i_req(req),
        .o_pop(pop), .m_out(m_out));

    a_pop_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> avail) else $error("pop from empty queue");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data))
        else $error("result dropped under stall");
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> !$isunknown(m_out.data))
        else $error("unknown result payload");
endmodule
